// ===== hw/rtl/epsilon_neighbourhood_mean_filter_assert.svh =====
// Assertion macros shared by the filter RTL.
`ifndef EPSILON_NEIGHBOURHOOD_MEAN_FILTER_ASSERT_SVH
`define EPSILON_NEIGHBOURHOOD_MEAN_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
`define ENMF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ENMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ENMF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ENMF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/enmf_pkg.sv =====
`default_nettype none
package enmf_pkg;

  localparam int KERNEL    = 3;
  localparam int MAX_WIDTH = 1024;
  localparam int BEFORE    = (KERNEL - 3) / 2 + 1;
  localparam int AFTER     = KERNEL - 1 - BEFORE;
  localparam int KK        = KERNEL * KERNEL;
  localparam int ROWS_KEPT = KERNEL + 1;
  localparam int SLOT_W    = $clog2(ROWS_KEPT);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int RAM_DEPTH = (1 << SLOT_W) << COL_W;
  localparam int ADDR_W    = SLOT_W + COL_W;
  localparam int CNT_W     = $clog2(KK + 1);
  localparam int SUM_W     = $clog2(KK * 255 + 1);
  localparam int LM_W      = $clog2(KERNEL);
  localparam int DC_W      = $clog2(SUM_W + 1);
  localparam int CW        = 11;
  localparam int RW        = 12;
  localparam int IW        = 14;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] filtered;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TAIL,
    ST_DIV,
    ST_RES
  } state_t;

  // reflect-101, clamped to the edge when still outside
  function automatic logic [RW-1:0] reflect(input logic signed [IW-1:0] idx,
                                            input logic [RW-1:0] n);
    logic signed [IW-1:0] v;
    logic signed [IW-1:0] ns;
    ns = signed'({{(IW-RW){1'b0}}, n});
    v  = idx;
    if (v < 0) v = -v;
    if (v >= ns) v = (ns <<< 1) - IW'(2) - v;
    if (v < 0) v = '0;
    if (v >= ns) v = ns - IW'(1);
    return v[RW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/enmf_ram.sv =====
`default_nettype none
module enmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/epsilon_neighbourhood_mean_filter.sv =====
// channel | ports                          | direction
// in      | in_valid, in_ready, in_data    | pixel or drain transaction in
// out     | out_valid, out_ready, out_data | filtered pixel out
// cfg     | cfg_valid, cfg_ready, cfg_*    | register write
//
// One transaction at a time. An item with no result is taken in ST_IDLE alone; one
// with a result reads the centre and window through the single RAM port (ST_READ),
// sums (ST_TAIL), divides bit-serially (ST_DIV, skipped if no pixel passes) and
// offers the result (ST_RES). Synchronous reset; the line store needs no
// clearing. cfg is always ready; out stalls hold the block until the result is taken.
`default_nettype none
`include "epsilon_neighbourhood_mean_filter_assert.svh"
module epsilon_neighbourhood_mean_filter (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire enmf_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output enmf_pkg::out_item_t     out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [11:0]        cfg_data
);
  import enmf_pkg::*;

  state_t state_r, state_nxt;

  logic [7:0]    thr_r;
  logic [CW-1:0] img_w_r, plane_w_r, in_col_r, out_col_r, c_r;
  logic [RW-1:0] img_h_r, plane_h_r, in_row_r, out_row_r, r_r;
  logic          last_r;
  logic [CNT_W-1:0] k_r;
  logic [LM_W-1:0]  l_r, m_r;
  logic          rd_vld_r, rd_first_r;
  logic [7:0]    centre_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] dvd_r, q_r;
  logic [CNT_W:0]   rem_r;
  logic [DC_W-1:0]  dc_r;
  logic [7:0]    res_r;

  logic [7:0]    rdata;
  logic          accept, first, do_write, do_emit;
  logic [CW-1:0] pw_eff;
  logic [RW-1:0] ph_eff;
  logic [RW+CW-1:0] q_pos, delay;
  logic [CW:0]   icol_inc, ocol_inc;
  logic [RW:0]   irow_inc, orow_inc;
  logic [CW-1:0] icol_n, ocol_n;
  logic [RW-1:0] irow_n, orow_n;
  logic          last_n;
  logic          rd_en;
  logic [LM_W:0] roff, coff;
  logic [RW-1:0] rr;
  logic [RW-1:0] cc;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [7:0]    diff;
  logic [CNT_W:0] trial;
  logic          ge;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign first     = (in_row_r == '0) && (in_col_r == '0) &&
                     (out_row_r == '0) && (out_col_r == '0);

  always_comb begin
    pw_eff = plane_w_r;
    ph_eff = plane_h_r;
    if (first && in_data.op == OP_PIXEL) begin
      if (img_w_r < CW'(2)) pw_eff = CW'(2);
      else if (img_w_r > CW'(MAX_WIDTH)) pw_eff = CW'(MAX_WIDTH);
      else pw_eff = img_w_r;
      ph_eff = (img_h_r < RW'(2)) ? RW'(2) : img_h_r;
    end
  end

  assign q_pos = (RW+CW)'(in_row_r) * (RW+CW)'(pw_eff) + (RW+CW)'(in_col_r);
  assign delay = (RW+CW)'(AFTER) * (RW+CW)'(pw_eff) + (RW+CW)'(AFTER);

  assign do_write = (in_data.op == OP_PIXEL) && (in_row_r < ph_eff);
  assign do_emit  = (in_data.op == OP_PIXEL) ? (do_write && q_pos >= delay)
                                             : (in_row_r >= plane_h_r);

  always_comb begin
    icol_inc = {1'b0, in_col_r} + 1'b1;
    irow_inc = {1'b0, in_row_r};
    icol_n   = in_col_r;
    irow_n   = in_row_r;
    if (do_write) begin
      if (icol_inc >= {1'b0, pw_eff}) begin
        icol_n   = '0;
        irow_inc = {1'b0, in_row_r} + 1'b1;
      end else begin
        icol_n = icol_inc[CW-1:0];
      end
      irow_n = irow_inc[RW-1:0];
    end
    ocol_inc = {1'b0, out_col_r} + 1'b1;
    orow_inc = {1'b0, out_row_r};
    if (ocol_inc >= {1'b0, pw_eff}) begin
      ocol_n   = '0;
      orow_inc = {1'b0, out_row_r} + 1'b1;
    end else begin
      ocol_n = ocol_inc[CW-1:0];
    end
    orow_n = orow_inc[RW-1:0];
    last_n = orow_inc >= {1'b0, ph_eff};
  end

  // window addressing: k=0 is the centre, then raster over the kernel
  always_comb begin
    roff  = (k_r == '0) ? (LM_W+1)'(BEFORE) : {1'b0, l_r};
    coff  = (k_r == '0) ? (LM_W+1)'(BEFORE) : {1'b0, m_r};
    rr    = reflect(signed'(IW'(r_r)) - IW'(BEFORE) + signed'(IW'(roff)), plane_h_r);
    cc    = reflect(signed'(IW'(c_r)) - IW'(BEFORE) + signed'(IW'(coff)),
                    {1'b0, plane_w_r});
    raddr = {rr[SLOT_W-1:0], cc[COL_W-1:0]};
    waddr = {in_row_r[SLOT_W-1:0], in_col_r[COL_W-1:0]};
  end

  enmf_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_line_store (
    .clk   (clk),
    .we    (accept && do_write),
    .waddr (waddr),
    .wdata (in_data.pixel),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    diff    = (rdata > centre_r) ? rdata - centre_r : centre_r - rdata;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (rd_vld_r && !rd_first_r && diff <= thr_r) begin
      sum_nxt = sum_r + SUM_W'(rdata);
      cnt_nxt = cnt_r + 1'b1;
    end
    trial = {rem_r[CNT_W-1:0], dvd_r[SUM_W-1]};
    ge    = trial >= {1'b0, cnt_r};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && do_emit) state_nxt = ST_READ;
      end
      ST_READ: begin
        if (k_r == CNT_W'(KK)) state_nxt = ST_TAIL;
      end
      ST_TAIL: begin
        state_nxt = (cnt_nxt == '0) ? ST_RES : ST_DIV;
      end
      ST_DIV: begin
        if (dc_r == DC_W'(SUM_W - 1)) state_nxt = ST_RES;
      end
      ST_RES: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    rd_en     = 1'b0;
    case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_READ: rd_en     = 1'b1;
      ST_RES:  out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_data.filtered = res_r;
  assign out_data.last     = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      thr_r     <= 8'd35;
      img_w_r   <= CW'(512);
      img_h_r   <= RW'(512);
      plane_w_r <= CW'(512);
      plane_h_r <= RW'(512);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      rd_vld_r  <= 1'b0;
      rd_first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD: thr_r   <= cfg_data[7:0];
          REG_WIDTH:     img_w_r <= cfg_data[CW-1:0];
          REG_HEIGHT:    img_h_r <= cfg_data;
          default: ;
        endcase
      end
      rd_vld_r   <= rd_en;
      rd_first_r <= rd_en && (k_r == '0);
      if (accept) begin
        plane_w_r <= pw_eff;
        plane_h_r <= ph_eff;
        if (do_emit && last_n) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end else begin
          in_col_r <= icol_n;
          in_row_r <= irow_n;
          if (do_emit) begin
            out_col_r <= ocol_n;
            out_row_r <= orow_n;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_r    <= out_row_r;
      c_r    <= out_col_r;
      last_r <= last_n;
      k_r    <= '0;
      l_r    <= '0;
      m_r    <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
    if (rd_vld_r && rd_first_r) begin
      centre_r <= rdata;
    end
    if (state_r == ST_READ) begin
      k_r <= k_r + 1'b1;
      if (k_r != '0) begin
        if (m_r == LM_W'(KERNEL - 1)) begin
          m_r <= '0;
          l_r <= l_r + 1'b1;
        end else begin
          m_r <= m_r + 1'b1;
        end
      end
    end
    if (state_r == ST_TAIL) begin
      dvd_r <= sum_nxt;
      rem_r <= '0;
      q_r   <= '0;
      dc_r  <= '0;
      res_r <= centre_r;
    end
    if (state_r == ST_DIV) begin
      dvd_r <= {dvd_r[SUM_W-2:0], 1'b0};
      rem_r <= ge ? trial - {1'b0, cnt_r} : trial;
      q_r   <= {q_r[SUM_W-2:0], ge};
      dc_r  <= dc_r + 1'b1;
      if (dc_r == DC_W'(SUM_W - 1)) begin
        res_r <= {q_r[6:0], ge};
      end
    end
  end

  `ENMF_ASSERT_IMPL(a_ready_excl, clk, rst_n, in_ready, !out_valid)
  `ENMF_ASSERT_IMPL(a_cnt_bound, clk, rst_n, state_r != ST_IDLE, cnt_r <= CNT_W'(KK))
  `ENMF_ASSERT_IMPL(a_col_bound, clk, rst_n, out_valid, out_col_r < plane_w_r)
  `ENMF_ASSERT_NEXT(a_read_done, clk, rst_n, state_r == ST_TAIL, !rd_vld_r)

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
  import enmf_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 60;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  epsilon_neighbourhood_mean_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // filter state as seen from outside
  logic [7:0] lines [ROWS_KEPT*MAX_WIDTH];
  int thr_reg, width_reg, height_reg;
  int in_col, in_row, out_col, out_row, plane_w, plane_h;

  out_item_t pending_pixels[$];
  int errors;
  int cycles;
  int send_idle_pct, recv_stall_pct, hold_off;
  int random_items;

  typedef struct {
    logic       op;
    logic [7:0] pixel;
    bit         typed;
    logic [7:0] filtered;
    logic       last;
  } stim_row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int mirror(input int idx, input int n);
    int v;
    v = idx;
    if (v < 0) v = -v;
    if (v >= n) v = 2 * n - 2 - v;
    if (v < 0) v = 0;
    if (v >= n) v = n - 1;
    return v;
  endfunction

  function automatic int pix_at(input int r, input int c);
    int rr, cc;
    rr = mirror(r, plane_h) % ROWS_KEPT;
    cc = mirror(c, plane_w);
    if (cc >= MAX_WIDTH) cc = MAX_WIDTH - 1;
    return lines[rr * MAX_WIDTH + cc];
  endfunction

  function automatic out_item_t sigma_mean();
    out_item_t res;
    int centre, sum, count, p, d;
    centre = pix_at(out_row, out_col);
    sum = 0;
    count = 0;
    for (int l = 0; l < KERNEL; l++) begin
      for (int m = 0; m < KERNEL; m++) begin
        p = pix_at(out_row - BEFORE + l, out_col - BEFORE + m);
        d = p > centre ? p - centre : centre - p;
        if (d <= thr_reg) begin
          sum += p;
          count++;
        end
      end
    end
    res.filtered = 8'(count != 0 ? sum / count : centre);
    res.last = 1'b0;
    out_col++;
    if (out_col >= plane_w) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= plane_h) begin
      res.last = 1'b1;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    end
    return res;
  endfunction

  function automatic bit filter_step(input in_item_t t, output out_item_t res);
    int q;
    res = '0;
    if (t.op == OP_PIXEL) begin
      if (in_row == 0 && in_col == 0 && out_row == 0 && out_col == 0) begin
        plane_w = width_reg < 2 ? 2 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
        plane_h = height_reg < 2 ? 2 : height_reg;
      end
      if (in_row >= plane_h) return 1'b0;
      lines[(in_row % ROWS_KEPT) * MAX_WIDTH + in_col] = t.pixel;
      q = in_row * plane_w + in_col;
      in_col++;
      if (in_col >= plane_w) begin
        in_col = 0;
        in_row++;
      end
      if (q >= AFTER * plane_w + AFTER) begin
        res = sigma_mean();
        return 1'b1;
      end
      return 1'b0;
    end
    if (in_row >= plane_h) begin
      res = sigma_mean();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report(input string msg);
    $display("mismatch @%0d: %s", cycles, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report("result with no transaction pending");
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.filtered !== want.filtered)
          report($sformatf("filtered %0d, want %0d", out_data.filtered, want.filtered));
        if (out_data.last !== want.last)
          report($sformatf("last %0d, want %0d", out_data.last, want.last));
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send(input in_item_t t, input bit typed, input out_item_t typed_res);
    out_item_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    if (filter_step(t, res)) pending_pixels.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 12'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_THRESHOLD: thr_reg = value & 8'hFF;
      REG_WIDTH: width_reg = value & 11'h7FF;
      REG_HEIGHT: height_reg = value & 12'hFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_op(input logic op, input int pixel);
    in_item_t t;
    t.op = op;
    t.pixel = 8'(pixel);
    send(t, 1'b0, '0);
    if (send_idle_pct >= 0) random_items++;
  endtask

  // one plane with random content plus noise: mid-plane drains, stray pixels
  task automatic random_plane();
    int w, h, base, p;
    w = width_reg < 2 ? 2 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h = height_reg < 2 ? 2 : height_reg;
    base = $urandom_range(0, 255);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 9) == 0) send_op(OP_DRAIN, $urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) begin
        p = $urandom_range(0, 255);
      end else begin
        p = base + $urandom_range(0, 80) - 40;
        p = p < 0 ? 0 : (p > 255 ? 255 : p);
      end
      send_op(OP_PIXEL, p);
    end
    if ($urandom_range(0, 4) == 0) send_op(OP_PIXEL, $urandom_range(0, 255));
    for (int i = 0; i < AFTER * w + AFTER; i++) send_op(OP_DRAIN, $urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) send_op(OP_DRAIN, 0);
  endtask

  stim_row_t directed [25] = '{
    '{OP_PIXEL, 8'd255, 1'b0, 8'd0, 1'b0},
    '{OP_PIXEL, 8'd255, 1'b0, 8'd0, 1'b0},
    '{OP_PIXEL, 8'd255, 1'b0, 8'd0, 1'b0},
    '{OP_PIXEL, 8'd255, 1'b1, 8'd255, 1'b0},
    '{OP_DRAIN, 8'd0, 1'b1, 8'd255, 1'b0},
    '{OP_DRAIN, 8'd0, 1'b1, 8'd255, 1'b0},
    '{OP_DRAIN, 8'd0, 1'b1, 8'd255, 1'b1},
    '{OP_DRAIN, 8'd0, 1'b0, 8'd0, 1'b0},
    '{OP_PIXEL, 8'd0, 1'b0, 8'd0, 1'b0},
    '{OP_PIXEL, 8'd200, 1'b0, 8'd0, 1'b0},
    '{OP_DRAIN, 8'd0, 1'b0, 8'd0, 1'b0},
    '{OP_PIXEL, 8'd100, 1'b0, 8'd0, 1'b0},
    '{OP_PIXEL, 8'd50, 1'b0, 8'd0, 1'b0},
    '{OP_PIXEL, 8'd7, 1'b0, 8'd0, 1'b0},
    '{OP_DRAIN, 8'd0, 1'b0, 8'd0, 1'b0},
    '{OP_DRAIN, 8'd0, 1'b0, 8'd0, 1'b0},
    '{OP_DRAIN, 8'd0, 1'b0, 8'd0, 1'b0},
    '{OP_DRAIN, 8'd0, 1'b0, 8'd0, 1'b0},
    '{OP_PIXEL, 8'd0, 1'b0, 8'd0, 1'b0},
    '{OP_PIXEL, 8'd0, 1'b0, 8'd0, 1'b0},
    '{OP_PIXEL, 8'd0, 1'b0, 8'd0, 1'b0},
    '{OP_PIXEL, 8'd0, 1'b1, 8'd0, 1'b0},
    '{OP_DRAIN, 8'd0, 1'b1, 8'd0, 1'b0},
    '{OP_DRAIN, 8'd0, 1'b1, 8'd0, 1'b0},
    '{OP_DRAIN, 8'd0, 1'b1, 8'd0, 1'b1}
  };

  initial begin
    in_item_t t;
    out_item_t te;
    int phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_items = 0;
    thr_reg = 35;
    width_reg = 512;
    height_reg = 512;
    plane_w = 512;
    plane_h = 512;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    foreach (lines[i]) lines[i] = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_WIDTH, 2);
    write_reg(REG_HEIGHT, 2);
    foreach (directed[i]) begin
      t.op = directed[i].op;
      t.pixel = directed[i].pixel;
      te.filtered = directed[i].filtered;
      te.last = directed[i].last;
      send(t, directed[i].typed, te);
    end
    settle();

    // full threshold, clipped width and height
    write_reg(REG_THRESHOLD, 255);
    write_reg(REG_HEIGHT, 0);
    write_reg(REG_WIDTH, 1);
    random_plane();
    settle();

    random_items = 0;
    while (random_items < 400) begin
      phase = random_items / 100;
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 85; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 85; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      write_reg(REG_THRESHOLD, $urandom_range(0, 5) == 0 ? 255 * $urandom_range(0, 1)
                                                        : $urandom_range(0, 255));
      write_reg(REG_WIDTH, $urandom_range(0, 7) == 0 ? $urandom_range(0, 1)
                                                     : $urandom_range(2, 9));
      write_reg(REG_HEIGHT, $urandom_range(0, 7) == 0 ? 0 : $urandom_range(2, 6));
      if (phase == 2 && hold_off == 0 && random_items < 215) begin
        send_idle_pct = 0;
        hold_off <= 300;
      end
      random_plane();
      settle();
    end

    recv_stall_pct = 0;
    settle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
